@@ rtl/core/utf8d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared result kinds, widths and the result beat type.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int BYTE_W  = 8;
   localparam int CODE_W  = 21;
   localparam int SHIFT_W = 6;
   localparam int KIND_W  = 2;

   localparam logic signed [SHIFT_W-1:0] SHIFT_STEP  = 6'sd6;
   localparam logic signed [SHIFT_W-1:0] SHIFT_LEAD2 = 6'sd0;
   localparam logic signed [SHIFT_W-1:0] SHIFT_LEAD3 = 6'sd6;
   localparam logic signed [SHIFT_W-1:0] SHIFT_LEAD4 = 6'sd12;
   localparam logic signed [SHIFT_W-1:0] SHIFT_MIN   = -6'sd6;

   localparam logic [0:0] CSR_DROP_MULTIBYTE = 1'b0;
   localparam logic [0:0] CSR_REPORT_ERRORS  = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ASCII   = 2'd0,
      KIND_CODE    = 2'd1,
      KIND_INVALID = 2'd2,
      KIND_EXCESS  = 2'd3
   } kind_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [CODE_W-1:0] value;
   } result_type;

endpackage

@@ rtl/core/utf8d_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder byte step
// Classifies one byte, updates the code accumulator and shift position, and
// forms the result beat, if any.
// ----------------------------------------------------------------------------
module utf8d_step
   import utf8d_pkg::*;
(
   input  logic [BYTE_W-1:0]         byte_in,
   input  logic [CODE_W-1:0]         acc,
   input  logic signed [SHIFT_W-1:0] shift,
   input  logic                      drop_multibyte,
   input  logic                      report_errors,
   output logic [CODE_W-1:0]         acc_next,
   output logic signed [SHIFT_W-1:0] shift_next,
   output result_type                result
);

   logic [CODE_W-1:0]         placed;
   logic [CODE_W-1:0]         acc_cont;
   logic signed [SHIFT_W-1:0] shift_cont;

   always_comb begin
      placed     = CODE_W'(byte_in[5:0]) << shift[4:0];
      acc_cont   = acc;
      shift_cont = shift;
      if (!shift[SHIFT_W-1]) begin
         acc_cont   = acc | placed;
         shift_cont = shift - SHIFT_STEP;
      end
   end

   always_comb begin
      acc_next     = acc;
      shift_next   = shift;
      result.valid = 1'b0;
      result.kind  = KIND_ASCII;
      result.value = CODE_W'(byte_in);
      if (!byte_in[7]) begin
         result.valid = 1'b1;
      end else if (!drop_multibyte) begin
         if (byte_in[7:6] == 2'b10) begin
            acc_next   = acc_cont;
            shift_next = shift_cont;
            if (shift_cont[SHIFT_W-1]) begin
               if (acc_cont != '0) begin
                  acc_next     = '0;
                  result.valid = 1'b1;
                  result.kind  = KIND_CODE;
                  result.value = acc_cont;
               end else begin
                  result.valid = report_errors;
                  result.kind  = KIND_EXCESS;
               end
            end
         end else if (byte_in[7:5] == 3'b110) begin
            acc_next   = {10'b0, byte_in[4:0], 6'b0};
            shift_next = SHIFT_LEAD2;
         end else if (byte_in[7:4] == 4'b1110) begin
            acc_next   = {5'b0, byte_in[3:0], 12'b0};
            shift_next = SHIFT_LEAD3;
         end else if (byte_in[7:3] == 5'b11110) begin
            acc_next   = {byte_in[2:0], 18'b0};
            shift_next = SHIFT_LEAD4;
         end else begin
            result.valid = report_errors;
            result.kind  = KIND_INVALID;
         end
      end
   end

endmodule

@@ rtl/core/utf8_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a UTF-8 byte stream into ASCII characters, code points and error
// beats, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one byte per clock unless rsp_ready stalls a pending result beat;
// gives at most one result beat per byte, through the input and result
// registers. The rate is set by the single decode step between the two; a byte
// that yields no result still passes through the step. Lead bytes and
// continuation bytes that do not finish a code point give no result; one
// ending at zero gives an error beat if reporting is on. Configuration writes
// take effect at once and are meant for idle periods only.
module utf8_stream_decoder
   import utf8d_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_byte_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [CODE_W-1:0] rsp_value,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic              csr_wdata
);

   logic                      in_valid_ff;
   logic [BYTE_W-1:0]         in_byte_ff;
   logic                      drop_ff;
   logic                      report_ff;
   logic [CODE_W-1:0]         acc_ff;
   logic [CODE_W-1:0]         acc_in;
   logic signed [SHIFT_W-1:0] shift_ff;
   logic signed [SHIFT_W-1:0] shift_in;
   result_type                res_ff;
   result_type                res_in;
   logic                      out_free;
   logic                      advance;

   assign out_free  = !res_ff.valid || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   utf8d_step u_step (
      .byte_in        (in_byte_ff),
      .acc            (acc_ff),
      .shift          (shift_ff),
      .drop_multibyte (drop_ff),
      .report_errors  (report_ff),
      .acc_next       (acc_in),
      .shift_next     (shift_in),
      .result         (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_ff   <= 1'b0;
         report_ff <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DROP_MULTIBYTE[0]: drop_ff   <= csr_wdata;
            CSR_REPORT_ERRORS[0]:  report_ff <= csr_wdata;
            default:               drop_ff   <= drop_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_in;
      end
   end

   // decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         shift_ff <= '0;
      end else if (advance) begin
         acc_ff   <= acc_in;
         shift_ff <= shift_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else if (out_free) begin
         res_ff.valid <= advance && res_in.valid;
      end
      if (advance) begin
         res_ff.kind  <= res_in.kind;
         res_ff.value <= res_in.value;
      end
   end

   assign rsp_valid = res_ff.valid;
   assign rsp_kind  = res_ff.kind;
   assign rsp_value = res_ff.value;

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (shift_ff >= SHIFT_MIN) && (shift_ff <= SHIFT_LEAD4))
      else $error("shift position out of range");

   a_code_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_CODE) |-> (rsp_value != '0))
      else $error("code point beat with zero value");

   a_ascii_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ASCII) |-> (rsp_value[CODE_W-1:7] == '0))
      else $error("ascii beat above 7 bits");

   a_clear_on_emit: assert property (@(posedge clock) disable iff (reset)
      advance && res_in.valid && (res_in.kind == KIND_CODE) |=> (acc_ff == '0))
      else $error("accumulator not cleared after code point");

   a_error_enabled: assert property (@(posedge clock) disable iff (reset)
      advance && res_in.valid && ((res_in.kind == KIND_INVALID) ||
      (res_in.kind == KIND_EXCESS)) |-> report_ff)
      else $error("error beat while reporting disabled");

endmodule

@@ tb/sv/tb_utf8_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Sends byte beats through the decoder under changing drop and error modes
// and changing back-pressure. Every accepted byte is run through a decoder
// model in the testbench, and each result beat is matched against the oldest
// predicted beat.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;
   import utf8d_pkg::*;

   localparam int HALF_PERIOD    = 2;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 215;

   typedef struct packed {
      kind_type          kind;
      logic [CODE_W-1:0] value;
   } decoded_beat_type;

   class result_tracker_type;
      bit                drop_on;
      bit                errors_on;
      logic [CODE_W-1:0] code_acc;
      int                bit_place;
      decoded_beat_type  expected_beats[$];
      int                mismatches;

      function new();
         drop_on    = 1'b0;
         errors_on  = 1'b1;
         code_acc   = '0;
         bit_place  = 0;
         mismatches = 0;
      endfunction

      function void set_modes(bit drop, bit report);
         drop_on   = drop;
         errors_on = report;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      function void push_beat(kind_type kind, logic [CODE_W-1:0] value);
         decoded_beat_type beat;
         beat.kind  = kind;
         beat.value = value;
         expected_beats.push_back(beat);
      endfunction

      // decode one accepted byte and queue the beat it produces, if any
      function void note_byte(logic [BYTE_W-1:0] b);
         logic [CODE_W-1:0] payload;
         int                lead_shift;
         if (!b[7]) begin
            push_beat(KIND_ASCII, CODE_W'(b));
            return;
         end
         if (drop_on) return;
         if (b[7:6] == 2'b10) begin
            if (bit_place >= 0) begin
               code_acc  = code_acc | CODE_W'(32'(b[5:0]) << bit_place);
               bit_place = bit_place - 6;
            end
            if (bit_place < 0) begin
               if (code_acc != '0) begin
                  push_beat(KIND_CODE, code_acc);
                  code_acc = '0;
               end else if (errors_on) begin
                  push_beat(KIND_EXCESS, CODE_W'(b));
               end
            end
            return;
         end
         casez (b)
            8'b110?????: begin
               lead_shift = 6;
               payload    = CODE_W'(b[4:0]);
            end
            8'b1110????: begin
               lead_shift = 12;
               payload    = CODE_W'(b[3:0]);
            end
            8'b11110???: begin
               lead_shift = 18;
               payload    = CODE_W'(b[2:0]);
            end
            default: begin
               if (errors_on) push_beat(KIND_INVALID, CODE_W'(b));
               return;
            end
         endcase
         code_acc  = CODE_W'(32'(payload) << lead_shift);
         bit_place = lead_shift - 6;
      endfunction

      function void check_result(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] value);
         decoded_beat_type want;
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat: kind %0d, value 0x%0h", kind, value);
            mismatches++;
            return;
         end
         want = expected_beats.pop_front();
         if (kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind);
            mismatches++;
         end
         if (value !== want.value) begin
            $error("value: expected 0x%0h, actual 0x%0h", want.value, value);
            mismatches++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [BYTE_W-1:0] req_byte_in;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [KIND_W-1:0] rsp_kind;
   logic [CODE_W-1:0] rsp_value;
   logic              csr_write_en;
   logic              csr_index;
   logic              csr_wdata;

   result_tracker_type tracker = new();

   int send_idle_pct;
   int recv_stall_pct;
   int counted_items;
   int idle_cycles;

   utf8_stream_decoder u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_byte_in  (req_byte_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_value    (rsp_value),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : monitor
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            tracker.note_byte(req_byte_in);
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            tracker.check_result(rsp_kind, rsp_value);
            moved = 1'b1;
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("utf8_stream_decoder regression: fail");
         $finish;
      end
   end

   // call at a falling edge; returns at the falling edge after the beat
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (!req_ready);
      counted_items++;
      @(negedge clock);
   endtask

   // lead byte for a len-byte sequence, then conts continuation bytes
   task automatic send_sequence(input int len, input int conts);
      logic [BYTE_W-1:0] lead;
      case (len)
         2:       lead = {3'b110, 5'($urandom)};
         3:       lead = {4'b1110, 4'($urandom)};
         default: lead = {5'b11110, 3'($urandom)};
      endcase
      send_byte(lead);
      repeat (conts) send_byte({2'b10, 6'($urandom)});
   endtask

   task automatic send_random(input int count);
      int target;
      int pick;
      int len;
      target = counted_items + count;
      while (counted_items < target) begin
         pick = $urandom_range(99);
         len  = $urandom_range(4, 2);
         if (pick < 30) begin
            send_byte(8'($urandom_range(127)));
         end else if (pick < 80) begin
            send_sequence(len, len - 1);
         end else if (pick < 90) begin
            send_sequence(len, $urandom_range(len - 2));
         end else begin
            send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   // hold the sender until every predicted beat has arrived
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_config(input bit drop, input bit report);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_DROP_MULTIBYTE[0];
      csr_wdata    <= drop;
      @(negedge clock);
      csr_index    <= CSR_REPORT_ERRORS[0];
      csr_wdata    <= report;
      @(negedge clock);
      csr_write_en <= 1'b0;
      tracker.set_modes(drop, report);
   endtask

   task automatic run_phase(input bit drop, input bit report, input int send_pct,
                            input int stall_pct);
      drain();
      write_config(drop, report);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      send_random(PHASE_ITEMS);
   endtask

   initial begin : stimulus
      logic [BYTE_W-1:0] directed[$];
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_byte_in    = '0;
      rsp_ready      = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = 1'b0;
      csr_wdata      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      counted_items  = 0;
      idle_cycles    = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // stray continuation from reset, then one with nothing left to place,
      // ASCII extremes, 3- and 4-byte forms up to the 21-bit maximum,
      // overlong zero, ASCII inside a sequence, lead replacing an open lead,
      // surrogate, invalid bytes
      directed = '{8'hBF, 8'h80, 8'h00, 8'h7F, 8'hE2, 8'h82, 8'hAC,
                   8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hC0, 8'h80,
                   8'hC3, 8'h41, 8'hA9, 8'hE1, 8'hC5, 8'h85, 8'hED,
                   8'hA0, 8'h80, 8'hF8, 8'hFF};
      foreach (directed[i]) send_byte(directed[i]);

      run_phase(1'b0, 1'b1, 0, 0);
      run_phase(1'b0, 1'b0, 76, 0);
      run_phase(1'b1, 1'b1, 0, 76);
      run_phase(1'b1, 1'b0, 10, 10);
      run_phase(1'b0, 1'b1, 10, 10);
      drain();

      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("utf8_stream_decoder regression: pass");
      end else begin
         $display("utf8_stream_decoder regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_step.sv
rtl/core/utf8_stream_decoder.sv
tb/sv/tb_utf8_stream_decoder.sv
